FILE: design/rct_pkg.sv
`timescale 1ns / 1ps

package rct_pkg;

  localparam int unsigned HueFracBitsDef = 16;
  localparam int unsigned QueueDepthDef  = 2;

  localparam int unsigned SumW     = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Reciprocals for exact division by small constants. With K equal to the
  // operand width, floor(x * floor(2^K / d) / 2^K) is the quotient or one less.
  localparam int unsigned DivK50   = 23;
  localparam int unsigned Recip50  = (1 << DivK50) / 50;
  localparam int unsigned DivK60   = 14;
  localparam int unsigned Recip60  = (1 << DivK60) / 60;
  localparam int unsigned DivK765  = 18;
  localparam int unsigned Recip765 = (1 << DivK765) / 765;

  // speed * dt * 3 at or above this always carries the hue past a full turn.
  localparam longint unsigned IncLimit = 360 * 256 * 50;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRainbowMode = 3'd0,
    CfgHueSpeed    = 3'd1,
    CfgFixedRed    = 3'd2,
    CfgFixedGreen  = 3'd3,
    CfgFixedBlue   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        rainbow_mode;
    logic [15:0] hue_speed;
    logic [7:0]  fixed_red;
    logic [7:0]  fixed_green;
    logic [7:0]  fixed_blue;
  } cfg_t;

  typedef struct packed {
    logic [31:0] tick_ms;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

  typedef enum logic [2:0] {
    FrIdle,
    FrMul,
    FrNum,
    FrDiv1,
    FrCor1,
    FrDiv2,
    FrCor2,
    FrPush
  } front_state_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkSect,
    BkDiv,
    BkCor,
    BkMul,
    BkRcp,
    BkOut
  } back_state_e;

endpackage

FILE: design/rct_front.sv
`timescale 1ns / 1ps

module rct_front #(
  parameter int unsigned HueFracBits = rct_pkg::HueFracBitsDef,
  localparam int unsigned HueW = 9 + HueFracBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rct_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rct_pkg::in_item_t         in_item_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output logic [HueW-1:0]           push_hue_o,
  output logic [rct_pkg::SumW-1:0]  push_sum_o,
  output logic                      push_rainbow_o
);

  localparam int unsigned Shift = HueFracBits - 8;
  localparam int unsigned SumW  = rct_pkg::SumW;
  localparam logic [HueW:0] HueFull = (HueW+1)'(360 * (longint'(1) << HueFracBits));

  rct_pkg::front_state_e state_q, state_d;

  logic [31:0]              last_tick_q, last_tick_d;
  logic [HueW-1:0]          hue_q, hue_d;
  logic [31:0]              dt_q, dt_d;
  logic [rct_pkg::SumW-1:0] sum_q, sum_d;
  logic                     rain_q, rain_d;
  logic [47:0]              prod_q, prod_d;
  logic                     over_q, over_d;
  logic [22:0]              x_q, x_d;
  logic [17:0]              q0_q, q0_d;
  logic [16:0]              quo_q, quo_d;
  logic [5:0]               rem_q, rem_d;
  logic [22:0]              y_q, y_d;
  logic [16:0]              q0b_q, q0b_d;
  logic [HueW-1:0]          inc_q, inc_d;
  logic [HueW:0]            hue_next;
  logic [HueW-1:0]          hue_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rct_pkg::FrIdle;
      last_tick_q <= '0;
      hue_q       <= '0;
    end else begin
      state_q     <= state_d;
      last_tick_q <= last_tick_d;
      hue_q       <= hue_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q   <= dt_d;
    sum_q  <= sum_d;
    rain_q <= rain_d;
    prod_q <= prod_d;
    over_q <= over_d;
    x_q    <= x_d;
    q0_q   <= q0_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    y_q    <= y_d;
    q0b_q  <= q0b_d;
    inc_q  <= inc_d;
  end

  always_comb begin
    logic [49:0] num;
    logic [40:0] xm;
    logic [22:0] rem1;
    logic [22:0] y;
    logic [40:0] ym;
    logic [22:0] rem2;
    logic [16:0] q2;

    state_d     = state_q;
    last_tick_d = last_tick_q;
    hue_d       = hue_q;
    dt_d        = dt_q;
    sum_d       = sum_q;
    rain_d      = rain_q;
    prod_d      = prod_q;
    over_d      = over_q;
    x_d         = x_q;
    q0_d        = q0_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    y_d         = y_q;
    q0b_d       = q0b_q;
    inc_d       = inc_q;
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;

    num  = {prod_q, 1'b0} + {2'b00, prod_q};
    xm   = 41'(x_q) * 41'(rct_pkg::Recip50);
    rem1 = x_q - 23'(23'(q0_q) * 23'd50);
    y    = 23'(rem_q) << Shift;
    ym   = 41'(y) * 41'(rct_pkg::Recip50);
    rem2 = y_q - 23'(23'(q0b_q) * 23'd50);
    q2   = (rem2 >= 23'd50) ? q0b_q + 17'd1 : q0b_q;

    // A hue that reaches a full turn, or a step known to be that large, wraps to zero.
    hue_next = (HueW+1)'(hue_q) + (HueW+1)'(inc_q);
    if (!rain_q) begin
      hue_new = hue_q;
    end else if (over_q || hue_next >= HueFull) begin
      hue_new = '0;
    end else begin
      hue_new = hue_next[HueW-1:0];
    end

    unique case (state_q)
      rct_pkg::FrIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          sum_d  = SumW'(in_item_i.in_red) + SumW'(in_item_i.in_green)
                 + SumW'(in_item_i.in_blue);
          rain_d = cfg_i.rainbow_mode;
          if (cfg_i.rainbow_mode) begin
            dt_d        = in_item_i.tick_ms - last_tick_q;
            last_tick_d = in_item_i.tick_ms;
            state_d     = rct_pkg::FrMul;
          end else begin
            state_d = rct_pkg::FrPush;
          end
        end
      end
      rct_pkg::FrMul: begin
        prod_d  = 48'(cfg_i.hue_speed) * 48'(dt_q);
        state_d = rct_pkg::FrNum;
      end
      rct_pkg::FrNum: begin
        over_d  = num >= 50'(rct_pkg::IncLimit);
        x_d     = num[22:0];
        state_d = (num >= 50'(rct_pkg::IncLimit)) ? rct_pkg::FrPush : rct_pkg::FrDiv1;
      end
      rct_pkg::FrDiv1: begin
        q0_d    = xm[40:23];
        state_d = rct_pkg::FrCor1;
      end
      rct_pkg::FrCor1: begin
        if (rem1 >= 23'd50) begin
          quo_d = 17'(q0_q) + 17'd1;
          rem_d = 6'(rem1 - 23'd50);
        end else begin
          quo_d = 17'(q0_q);
          rem_d = 6'(rem1);
        end
        state_d = rct_pkg::FrDiv2;
      end
      rct_pkg::FrDiv2: begin
        y_d     = y;
        q0b_d   = 17'(ym[40:23]);
        state_d = rct_pkg::FrCor2;
      end
      rct_pkg::FrCor2: begin
        inc_d   = (HueW'(quo_q) << Shift) + HueW'(q2);
        state_d = rct_pkg::FrPush;
      end
      rct_pkg::FrPush: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          hue_d   = hue_new;
          state_d = rct_pkg::FrIdle;
        end
      end
      default: state_d = rct_pkg::FrIdle;
    endcase
  end

  assign push_hue_o     = hue_new;
  assign push_sum_o     = sum_q;
  assign push_rainbow_o = rain_q;

endmodule

FILE: design/rct_queue.sv
`timescale 1ns / 1ps

module rct_queue #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = rct_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/rct_back.sv
`timescale 1ns / 1ps

module rct_back #(
  parameter int unsigned HueFracBits = rct_pkg::HueFracBitsDef,
  localparam int unsigned HueW = 9 + HueFracBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rct_pkg::cfg_t             cfg_i,
  input  logic                      pop_valid_i,
  output logic                      pop_ready_o,
  input  logic [HueW-1:0]           pop_hue_i,
  input  logic [rct_pkg::SumW-1:0]  pop_sum_i,
  input  logic                      pop_rainbow_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rct_pkg::out_item_t        out_item_o
);

  localparam int unsigned SecW  = 6 + HueFracBits;
  localparam int unsigned ProdW = 14 + HueFracBits;
  localparam logic [HueW-1:0] Sector = HueW'(60 * (longint'(1) << HueFracBits));

  rct_pkg::back_state_e state_q, state_d;

  logic                     out_valid_q, out_valid_d;
  rct_pkg::out_item_t       out_q, out_d;
  logic [HueW-1:0]          hue_q, hue_d;
  logic [rct_pkg::SumW-1:0] sum_q, sum_d;
  logic                     rain_q, rain_d;
  logic [2:0]               k_q, k_d;
  logic [13:0]              t_q, t_d;
  logic                     lowz_q, lowz_d;
  logic [8:0]               q0_q, q0_d;
  logic [7:0]               col_q [3];
  logic [7:0]               col_d [3];
  logic [17:0]              p_q [3];
  logic [17:0]              p_d [3];
  logic [8:0]               qs_q [3];
  logic [8:0]               qs_d [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rct_pkg::BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hue_q  <= hue_d;
    sum_q  <= sum_d;
    rain_q <= rain_d;
    k_q    <= k_d;
    t_q    <= t_d;
    lowz_q <= lowz_d;
    q0_q   <= q0_d;
    col_q  <= col_d;
    p_q    <= p_d;
    qs_q   <= qs_d;
  end

  always_comb begin
    logic [2:0]       k;
    logic [HueW-1:0]  base;
    logic [SecW-1:0]  rem;
    logic [ProdW-1:0] prod;
    logic [22:0]      tm;
    logic [13:0]      r60;
    logic [7:0]       up;
    logic [7:0]       down;
    logic             exact;
    logic [26:0]      pm;
    logic [17:0]      r765;
    logic [7:0]       res [3];

    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    hue_d       = hue_q;
    sum_d       = sum_q;
    rain_d      = rain_q;
    k_d         = k_q;
    t_d         = t_q;
    lowz_d      = lowz_q;
    q0_d        = q0_q;
    col_d       = col_q;
    p_d         = p_q;
    qs_d        = qs_q;
    pop_ready_o = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Sector of the hue, and its offset within the sector.
    priority if (hue_q >= HueW'(5 * Sector)) begin
      k = 3'd5;
    end else if (hue_q >= HueW'(4 * Sector)) begin
      k = 3'd4;
    end else if (hue_q >= HueW'(3 * Sector)) begin
      k = 3'd3;
    end else if (hue_q >= HueW'(2 * Sector)) begin
      k = 3'd2;
    end else if (hue_q >= Sector) begin
      k = 3'd1;
    end else begin
      k = 3'd0;
    end
    base = HueW'(HueW'(k) * Sector);
    rem  = SecW'(hue_q - base);
    prod = (ProdW'(rem) << 8) - ProdW'(rem);

    tm  = 23'(t_q) * 23'(rct_pkg::Recip60);
    r60 = t_q - 14'(14'(q0_q) * 14'd60);
    up  = (r60 >= 14'd60) ? 8'(q0_q + 9'd1) : 8'(q0_q);
    // The falling channel is 255 - up only when the rising one is exact.
    exact = lowz_q && ((r60 == 14'd0) || (r60 == 14'd60));
    down  = exact ? 8'd255 - up : 8'd254 - up;

    for (int i = 0; i < 3; i++) begin
      pm   = 27'(p_q[i]) * 27'(rct_pkg::Recip765);
      r765 = p_q[i] - 18'(18'(qs_q[i]) * 18'd765);
      res[i] = (r765 >= 18'd765) ? 8'(qs_q[i] + 9'd1) : 8'(qs_q[i]);
      if (state_q == rct_pkg::BkRcp) begin
        qs_d[i] = pm[26:18];
      end
      if (state_q == rct_pkg::BkMul) begin
        p_d[i] = 18'(col_q[i]) * 18'(sum_q);
      end
    end

    unique case (state_q)
      rct_pkg::BkIdle: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          hue_d   = pop_hue_i;
          sum_d   = pop_sum_i;
          rain_d  = pop_rainbow_i;
          state_d = rct_pkg::BkSect;
        end
      end
      rct_pkg::BkSect: begin
        k_d     = k;
        t_d     = prod[ProdW-1:HueFracBits];
        lowz_d  = prod[HueFracBits-1:0] == '0;
        state_d = rct_pkg::BkDiv;
      end
      rct_pkg::BkDiv: begin
        q0_d    = tm[22:14];
        state_d = rct_pkg::BkCor;
      end
      rct_pkg::BkCor: begin
        if (!rain_q) begin
          col_d[0] = cfg_i.fixed_red;
          col_d[1] = cfg_i.fixed_green;
          col_d[2] = cfg_i.fixed_blue;
        end else begin
          unique case (k_q)
            3'd0: begin
              col_d[0] = 8'd255; col_d[1] = up;     col_d[2] = 8'd0;
            end
            3'd1: begin
              col_d[0] = down;   col_d[1] = 8'd255; col_d[2] = 8'd0;
            end
            3'd2: begin
              col_d[0] = 8'd0;   col_d[1] = 8'd255; col_d[2] = up;
            end
            3'd3: begin
              col_d[0] = 8'd0;   col_d[1] = down;   col_d[2] = 8'd255;
            end
            3'd4: begin
              col_d[0] = up;     col_d[1] = 8'd0;   col_d[2] = 8'd255;
            end
            default: begin
              col_d[0] = 8'd255; col_d[1] = 8'd0;   col_d[2] = down;
            end
          endcase
        end
        state_d = rct_pkg::BkMul;
      end
      rct_pkg::BkMul: begin
        state_d = rct_pkg::BkRcp;
      end
      rct_pkg::BkRcp: begin
        state_d = rct_pkg::BkOut;
      end
      rct_pkg::BkOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.out_red   = res[0];
          out_d.out_green = res[1];
          out_d.out_blue  = res[2];
          out_valid_d     = 1'b1;
          state_d         = rct_pkg::BkIdle;
        end
      end
      default: state_d = rct_pkg::BkIdle;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: design/rainbow_color_tinter.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  in_item_i (tick_ms, in_red, in_green, in_blue)
// out       output     out_valid_o/out_ready_i out_item_o (out_red, out_green, out_blue)
// cfg       input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// The back end steps through sector, divide by 60, color pick, two-step divide
// by 765 and output load for each item; it sets the rate for fixed items.
// A rainbow item holds the front end for the hue step multiply and, unless the
// step is a full turn or more, two divide-by-50 passes before it takes another.
// Reset clears hue, last tick, the queue and the output valid flag at once.
// A stalled output holds the back end; the queue (two entries by default) lets
// the front keep taking requests meanwhile, until the queue is full.

module rainbow_color_tinter #(
  parameter int unsigned HueFracBits = rct_pkg::HueFracBitsDef,
  parameter int unsigned QueueDepth  = rct_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rct_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rct_pkg::out_item_t           out_item_o,
  input  logic                         cfg_we_i,
  input  logic [rct_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rct_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned HueW   = 9 + HueFracBits;
  localparam int unsigned EntryW = 1 + rct_pkg::SumW + HueW;

  rct_pkg::cfg_t cfg_q;

  logic                     q_push_valid, q_push_ready;
  logic                     q_pop_valid, q_pop_ready;
  logic [HueW-1:0]          push_hue, pop_hue;
  logic [rct_pkg::SumW-1:0] push_sum, pop_sum;
  logic                     push_rain, pop_rain;
  logic [EntryW-1:0]        push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rainbow_mode <= 1'b0;
      cfg_q.hue_speed    <= 16'd256;
      cfg_q.fixed_red    <= 8'd255;
      cfg_q.fixed_green  <= 8'd0;
      cfg_q.fixed_blue   <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rct_pkg::CfgRainbowMode: cfg_q.rainbow_mode <= cfg_wdata_i[0];
        rct_pkg::CfgHueSpeed:    cfg_q.hue_speed    <= cfg_wdata_i;
        rct_pkg::CfgFixedRed:    cfg_q.fixed_red    <= cfg_wdata_i[7:0];
        rct_pkg::CfgFixedGreen:  cfg_q.fixed_green  <= cfg_wdata_i[7:0];
        rct_pkg::CfgFixedBlue:   cfg_q.fixed_blue   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  rct_front #(
    .HueFracBits(HueFracBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .push_valid_o  (q_push_valid),
    .push_ready_i  (q_push_ready),
    .push_hue_o    (push_hue),
    .push_sum_o    (push_sum),
    .push_rainbow_o(push_rain)
  );

  assign push_data = {push_rain, push_sum, push_hue};

  rct_queue #(
    .Width(EntryW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(q_push_valid),
    .push_ready_o(q_push_ready),
    .push_data_i (push_data),
    .pop_valid_o (q_pop_valid),
    .pop_ready_i (q_pop_ready),
    .pop_data_o  (pop_data)
  );

  assign {pop_rain, pop_sum, pop_hue} = pop_data;

  rct_back #(
    .HueFracBits(HueFracBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (q_pop_valid),
    .pop_ready_o  (q_pop_ready),
    .pop_hue_i    (pop_hue),
    .pop_sum_i    (pop_sum),
    .pop_rainbow_i(pop_rain),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

  // The front end works on one request at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("front accepted a request while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !q_push_valid)
    else $error("front pushes while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_valid && q_pop_ready |=> !q_pop_ready)
    else $error("back end popped the queue while busy");

endmodule
